### hw/rtl/lookahead_waypoint_select_assert.svh
// Assertion macros shared by the lookahead waypoint select RTL.
`ifndef LOOKAHEAD_WAYPOINT_SELECT_ASSERT_SVH
`define LOOKAHEAD_WAYPOINT_SELECT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LWS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LWS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lws_pkg.sv
// Shared constants, payload types and queue entry type for the waypoint selector.
package lws_pkg;

  // Sizing
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned HEAD_W     = 16;
  localparam int unsigned THR_W      = 23;
  localparam int unsigned THRSQ_W    = 2 * THR_W;
  localparam int unsigned NEXT_W     = 10;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned SQ_W       = 2 * COORD_BITS;
  localparam int unsigned DIST_W     = SQ_W + 1;
  localparam int unsigned BEST_W     = DIST_W + 1;
  localparam int unsigned DOT_W      = DIFF_W + HEAD_W;
  localparam int unsigned DOTSUM_W   = DOT_W + 1;

  // Command queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1280);
  localparam logic [HEAD_W-1:0] COS_RESET = HEAD_W'(16384);

  // Input command codes
  localparam logic [1:0] CMD_POSE = 2'd0;
  localparam logic [1:0] CMD_PUSH = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Classified operation held in the queue
  typedef enum logic [1:0] {
    OP_POSE = 2'd0,
    OP_PUSH = 2'd1,
    OP_END  = 2'd2
  } lws_op_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [HEAD_W-1:0]     heading_cos;
    logic signed [HEAD_W-1:0]     heading_sin;
  } lws_item_t;

  typedef struct packed {
    logic [NEXT_W-1:0] next_index;
    logic              hit_ahead;
    logic              overflowed;
  } lws_result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } lws_point_t;

  typedef struct packed {
    lws_op_e                  op;
    lws_point_t               pt;
    logic signed [HEAD_W-1:0] hcos;
    logic signed [HEAD_W-1:0] hsin;
  } lws_qent_t;

endpackage

### hw/rtl/lws_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
module lws_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lws_pkg::lws_item_t item_i,
  output lws_pkg::lws_qent_t q_ent_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);
  import lws_pkg::*;

  lws_qent_t         ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept, keep, push, pop;
  lws_qent_t         ent_new;

  assign busy   = (cnt_q == QCNT_W'(QDEPTH));
  assign accept = start && !busy;

  // Classify the command; the unused code is taken and dropped
  always_comb begin
    ent_new.pt.x = item_i.coord_x;
    ent_new.pt.y = item_i.coord_y;
    ent_new.hcos = item_i.heading_cos;
    ent_new.hsin = item_i.heading_sin;
    keep         = 1'b1;
    ent_new.op   = OP_POSE;
    unique case (item_i.command)
      CMD_POSE: ent_new.op = OP_POSE;
      CMD_PUSH: ent_new.op = OP_PUSH;
      CMD_END:  ent_new.op = OP_END;
      default:  keep = 1'b0;
    endcase
  end

  assign push = accept && keep;
  assign pop  = q_pop_i && (cnt_q != '0);

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= ent_new;
    end
  end

  // Queue pointers and fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  assign q_ent_o   = ent_q[rd_ptr_q];
  assign q_valid_o = (cnt_q != '0);

`include "lookahead_waypoint_select_assert.svh"

  `LWS_ASSERT_IMP(a_q_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count over depth")
  `LWS_ASSERT_NXT(a_q_grow, push && !pop, cnt_q == QCNT_W'($past(cnt_q) + 1'b1), "lost transfer")
  `LWS_ASSERT_IMP(a_q_full, busy, !push, "transfer into a full queue")

endmodule

### hw/rtl/lws_back.sv
// Back end: waypoint store, nearest-point tracking and the forward lookahead scan.
module lws_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lws_pkg::lws_qent_t   q_ent_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  logic                 cfg_we_i,
  input  logic [lws_pkg::THR_W-1:0] cfg_wdata_i,
  output logic                 done_o,
  output lws_pkg::lws_result_t result_o
);
  import lws_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_DIF  = 6'b000100,
    S_MUL  = 6'b001000,
    S_CHK  = 6'b010000,
    S_ACC  = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;

  // Waypoint store
  lws_point_t mem [MAX_POINTS];
  lws_point_t rd_q;

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [BEST_W-1:0]          best_q, best_d;
  logic [IDX_W-1:0]           best_idx_q, best_idx_d;
  logic                       drop_q, drop_d;
  logic signed [COORD_BITS-1:0] pose_x_q, pose_x_d, pose_y_q, pose_y_d;
  logic signed [HEAD_W-1:0]   pose_cos_q, pose_cos_d, pose_sin_q, pose_sin_d;
  logic [THR_W-1:0]           thr_q;
  logic [THRSQ_W-1:0]         thr_sq_q, thr_sq_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic                       scan_q, scan_d;
  logic signed [DIFF_W-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [SQ_W-1:0]            sqx_q, sqx_d, sqy_q, sqy_d;
  logic signed [DOT_W-1:0]    dotx_q, dotx_d, doty_q, doty_d;
  logic                       done_d;
  lws_result_t                res_q, res_d;

  logic                       pop, wr_en;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  logic [DIST_W-1:0]          dsq;
  logic signed [DOTSUM_W-1:0] dot_sum;
  logic                       ahead, far, last;

  assign pop     = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o = pop;
  assign wr_en   = pop && (q_ent_i.op == OP_PUSH) && (cnt_q != CNT_W'(MAX_POINTS));

  // Shared multiply stage and the sums that follow it
  assign sqx_full = (2*DIFF_W)'(dx_q) * (2*DIFF_W)'(dx_q);
  assign sqy_full = (2*DIFF_W)'(dy_q) * (2*DIFF_W)'(dy_q);
  assign dsq      = DIST_W'(sqx_q) + DIST_W'(sqy_q);
  assign dot_sum  = DOTSUM_W'(dotx_q) + DOTSUM_W'(doty_q);
  assign ahead    = !dot_sum[DOTSUM_W-1] && (dot_sum != '0);
  assign far      = dsq > DIST_W'(thr_sq_q);
  assign last     = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    drop_d     = drop_q;
    pose_x_d   = pose_x_q;
    pose_y_d   = pose_y_q;
    pose_cos_d = pose_cos_q;
    pose_sin_d = pose_sin_q;
    thr_sq_d   = thr_sq_q;
    idx_d      = idx_q;
    scan_d     = scan_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    sqx_d      = sqx_q;
    sqy_d      = sqy_q;
    dotx_d     = dotx_q;
    doty_d     = doty_q;
    done_d     = 1'b0;
    res_d      = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_ent_i.op)
            OP_POSE: begin
              pose_x_d   = q_ent_i.pt.x;
              pose_y_d   = q_ent_i.pt.y;
              pose_cos_d = q_ent_i.hcos;
              pose_sin_d = q_ent_i.hsin;
              cnt_d      = '0;
              best_d     = '1;
              best_idx_d = '0;
              drop_d     = 1'b0;
            end
            OP_PUSH: begin
              if (cnt_q == CNT_W'(MAX_POINTS)) begin
                drop_d = 1'b1;
              end else begin
                dx_d    = DIFF_W'(q_ent_i.pt.x) - DIFF_W'(pose_x_q);
                dy_d    = DIFF_W'(q_ent_i.pt.y) - DIFF_W'(pose_y_q);
                scan_d  = 1'b0;
                state_d = S_MUL;
              end
            end
            OP_END: begin
              if (cnt_q == '0) begin
                done_d           = 1'b1;
                res_d.next_index = '0;
                res_d.hit_ahead  = 1'b0;
                res_d.overflowed = drop_q;
                best_d           = '1;
                best_idx_d       = '0;
                drop_d           = 1'b0;
              end else begin
                thr_sq_d = THRSQ_W'(thr_q) * THRSQ_W'(thr_q);
                idx_d    = best_idx_q;
                scan_d   = 1'b1;
                state_d  = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_d = S_DIF;
      end
      S_DIF: begin
        dx_d    = DIFF_W'(rd_q.x) - DIFF_W'(pose_x_q);
        dy_d    = DIFF_W'(rd_q.y) - DIFF_W'(pose_y_q);
        state_d = S_MUL;
      end
      S_MUL: begin
        sqx_d   = sqx_full[SQ_W-1:0];
        sqy_d   = sqy_full[SQ_W-1:0];
        dotx_d  = DOT_W'(dx_q) * DOT_W'(pose_cos_q);
        doty_d  = DOT_W'(dy_q) * DOT_W'(pose_sin_q);
        state_d = scan_q ? S_CHK : S_ACC;
      end
      S_ACC: begin
        // Nearest tracking: strict less keeps the earlier point on a tie
        if ((cnt_q == '0) || (BEST_W'(dsq) < best_q)) begin
          best_d     = BEST_W'(dsq);
          best_idx_d = cnt_q[IDX_W-1:0];
        end
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_IDLE;
      end
      S_CHK: begin
        if ((ahead && far) || last) begin
          done_d            = 1'b1;
          res_d.next_index  = NEXT_W'((ahead && far) ? idx_q : best_idx_q);
          res_d.hit_ahead   = ahead && far;
          res_d.overflowed  = drop_q;
          cnt_d             = '0;
          best_d            = '1;
          best_idx_d        = '0;
          drop_d            = 1'b0;
          state_d           = S_IDLE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Store write on push, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= q_ent_i.pt;
    end
    if (state_q == S_RD) begin
      rd_q <= mem[idx_q];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_sq_d;
    idx_q    <= idx_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sqx_q    <= sqx_d;
    sqy_q    <= sqy_d;
    dotx_q   <= dotx_d;
    doty_q   <= doty_d;
    res_q    <= res_d;
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      best_q     <= '1;
      best_idx_q <= '0;
      drop_q     <= 1'b0;
      pose_x_q   <= '0;
      pose_y_q   <= '0;
      pose_cos_q <= COS_RESET;
      pose_sin_q <= '0;
      thr_q      <= THR_RESET;
      scan_q     <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
      drop_q     <= drop_d;
      pose_x_q   <= pose_x_d;
      pose_y_q   <= pose_y_d;
      pose_cos_q <= pose_cos_d;
      pose_sin_q <= pose_sin_d;
      scan_q     <= scan_d;
      done_o     <= done_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  assign result_o = res_q;

`include "lookahead_waypoint_select_assert.svh"

  `LWS_ASSERT_IMP(a_done_idle, done_o, state_q == S_IDLE, "result while still busy")
  `LWS_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CNT_W'(MAX_POINTS), "point count over capacity")
  `LWS_ASSERT_IMP(a_scan_rng, state_q == S_CHK, CNT_W'(idx_q) < cnt_q, "scan past last point")

endmodule

### hw/rtl/lookahead_waypoint_select.sv
// Top level of the lookahead waypoint selector: command front end, queue and back end.
//
// Usage: drive item_i and raise start; the item transfers on a clock edge with start
// high and busy low. Commands: set pose (also clears the path), push waypoint, end of
// path. Only the end command gives a result, on result_o with done_o high for exactly
// one cycle; the receiver cannot stall it. reach_threshold is written with
// cfg_we_i/cfg_wdata_i while the block is idle.
// Items go into a four-entry queue, so the front takes one item per cycle until the
// queue fills; an idle back end picks an item up in the cycle after its transfer.
// The back end takes a pose or a dropped waypoint in its idle state alone; a stored
// waypoint goes through subtract, multiply and compare. An end command on an empty
// path answers from the idle state; otherwise each waypoint scanned from the nearest
// one needs a store read, subtract, multiply and compare in turn on the single read
// port and shared multipliers. done_o is high in the cycle after the last of these.
// Reset clears the pose (heading 1.0, 0), the path and the queue, and sets the
// threshold to 1280; the waypoint store itself is not cleared and needs no sweep.
module lookahead_waypoint_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  lws_pkg::lws_item_t        item_i,
  input  logic                      cfg_we_i,
  input  logic [lws_pkg::THR_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output lws_pkg::lws_result_t      result_o
);
  import lws_pkg::*;

  lws_qent_t q_ent;
  logic      q_pop;
  logic      q_valid;

  // Front end with the command queue
  lws_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .q_ent_o   (q_ent),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  // Back end with store and scan
  lws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_ent_i     (q_ent),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

### test/lws_selection_check.sv
// Checker for the waypoint selector: follows the command stream, predicts each selection, compares.
module lws_selection_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  lws_pkg::lws_item_t        item_i,
  input  logic                      cfg_we_i,
  input  logic [lws_pkg::THR_W-1:0] cfg_wdata_i,
  input  logic                      done_i,
  input  lws_pkg::lws_result_t      result_i,
  output int                        outstanding_o,
  output int                        errors_o,
  output int                        checked_o,
  output int                        ahead_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lws_pkg::*;

  // Shadow copy of the path, pose and threshold
  lws_point_t               path_pts [MAX_POINTS];
  logic [CNT_W-1:0]         path_len;
  lws_point_t               pose_pos;
  logic signed [HEAD_W-1:0] pose_cos;
  logic signed [HEAD_W-1:0] pose_sin;
  logic [BEST_W-1:0]        nearest_dist;
  logic [IDX_W-1:0]         nearest_idx;
  logic                     dropped;
  logic [THR_W-1:0]         reach_limit;

  // Selections predicted but not yet seen on the result port
  lws_result_t              pending_sel [$];
  int                       mismatches;
  int                       checked;
  int                       ahead_hits;

  function automatic longint off_x(lws_point_t p);
    return longint'($signed(p.x)) - longint'($signed(pose_pos.x));
  endfunction

  function automatic longint off_y(lws_point_t p);
    return longint'($signed(p.y)) - longint'($signed(pose_pos.y));
  endfunction

  // Squared distance to the pose, exact
  function automatic logic [BEST_W-1:0] range_sq(lws_point_t p);
    longint dx;
    longint dy;
    dx = off_x(p);
    dy = off_y(p);
    return BEST_W'(dx * dx + dy * dy);
  endfunction

  // Ahead means a strictly positive projection on the heading
  function automatic logic lies_ahead(lws_point_t p);
    longint dot;
    dot = off_x(p) * longint'(pose_cos) + off_y(p) * longint'(pose_sin);
    return dot > 0;
  endfunction

  // Walk forward from the nearest point for the first one ahead and past the threshold
  function automatic lws_result_t select_target();
    lws_result_t       r;
    logic [BEST_W-1:0] limit_sq;
    int                i;
    limit_sq = BEST_W'(longint'(reach_limit) * longint'(reach_limit));
    r.next_index  = '0;
    r.hit_ahead   = 1'b0;
    r.overflowed  = dropped;
    if (path_len != 0) begin
      r.next_index = NEXT_W'(nearest_idx);
      for (i = int'(nearest_idx); i < int'(path_len) && !r.hit_ahead; i++) begin
        if (lies_ahead(path_pts[i]) && range_sq(path_pts[i]) > limit_sq) begin
          r.next_index  = NEXT_W'(i);
          r.hit_ahead   = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic clear_path();
    path_len     = '0;
    nearest_dist = '1;
    nearest_idx  = '0;
    dropped      = 1'b0;
  endtask

  // Update the shadow state for one accepted command
  task automatic apply_item(lws_item_t it);
    lws_point_t        p;
    logic [BEST_W-1:0] d;
    p.x = it.coord_x;
    p.y = it.coord_y;
    case (it.command)
      CMD_POSE: begin
        pose_pos = p;
        pose_cos = it.heading_cos;
        pose_sin = it.heading_sin;
        clear_path();
      end
      CMD_PUSH: begin
        if (path_len >= CNT_W'(MAX_POINTS)) begin
          dropped = 1'b1;
        end else begin
          path_pts[path_len[IDX_W-1:0]] = p;
          d = range_sq(p);
          // strict compare keeps the earlier point on a tie
          if (path_len == 0 || d < nearest_dist) begin
            nearest_dist = d;
            nearest_idx  = path_len[IDX_W-1:0];
          end
          path_len = path_len + 1'b1;
        end
      end
      CMD_END: begin
        pending_sel = {pending_sel, select_target()};
        clear_path();
      end
      default: ;
    endcase
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic compare_result(lws_result_t got);
    lws_result_t want;
    checked++;
    if (got.hit_ahead === 1'b1) ahead_hits++;
    if (pending_sel.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: selection with nothing outstanding: idx %0d ahead %b ovf %b",
                 $time, got.next_index, got.hit_ahead, got.overflowed);
      return;
    end
    want = pending_sel.pop_front();
    if (got.next_index !== want.next_index || got.hit_ahead !== want.hit_ahead ||
        got.overflowed !== want.overflowed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: selection mismatch: want idx %0d ahead %b ovf %b, got idx %0d ahead %b ovf %b",
                 $time, want.next_index, want.hit_ahead, want.overflowed,
                 got.next_index, got.hit_ahead, got.overflowed);
    end
  endtask

  // Sample on the rising edge; results first, since a new command never answers in its own cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_pos    = '0;
      pose_cos    = COS_RESET;
      pose_sin    = '0;
      reach_limit = THR_RESET;
      clear_path();
      pending_sel.delete();
      mismatches  = 0;
      checked     = 0;
      ahead_hits  = 0;
    end else begin
      if (done_i) compare_result(result_i);
      if (cfg_we_i) reach_limit = cfg_wdata_i;
      if (start_i && !busy_i) apply_item(item_i);
    end
    outstanding_o = pending_sel.size();
    errors_o      = mismatches;
    checked_o     = checked;
    ahead_hits_o  = ahead_hits;
  end

endmodule

### test/lookahead_waypoint_select_tb.sv
// Testbench top for the waypoint selector: clock, reset, command stimulus and verdict.
module lookahead_waypoint_select_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lws_pkg::*;

  // Unused command code; the block must ignore it
  localparam logic [1:0] CMD_NONE    = 2'd3;
  // Random section budget; the capacity fill already sends over a thousand items
  localparam int         RAND_ITEMS  = 160;
  localparam int         QUIET_TAIL  = 40;
  localparam int         COORD_MAX   = 8388607;
  localparam int         COORD_MIN   = -8388608;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  lws_item_t         item_i;
  logic              cfg_we_i;
  logic [THR_W-1:0]  cfg_wdata_i;
  logic              done_o;
  lws_result_t       result_o;

  int                outstanding;
  int                errors;
  int                checked;
  int                ahead_hits;

  int                sent;
  int                settings;
  logic              gaps_on;
  logic [THR_W-1:0]  reach_now;
  int                pose_x_now;
  int                pose_y_now;

  lookahead_waypoint_select DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  lws_selection_check sel_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (item_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_i        (done_o),
    .result_i      (result_o),
    .outstanding_o (outstanding),
    .errors_o      (errors),
    .checked_o     (checked),
    .ahead_hits_o  (ahead_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #(5_000_000);
    $display("watchdog expired with %0d selections outstanding", outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic lws_item_t pack_cmd(logic [1:0] cmd, int x, int y, int c, int s);
    lws_item_t r;
    r.command     = cmd;
    r.coord_x     = COORD_BITS'(x);
    r.coord_y     = COORD_BITS'(y);
    r.heading_cos = HEAD_W'(c);
    r.heading_sin = HEAD_W'(s);
    return r;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 16777215)) + COORD_MIN;
  endfunction

  function automatic int coord_near(int center, int span);
    longint v;
    v = longint'(center) + longint'($urandom_range(0, 2 * span)) - longint'(span);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return int'(v);
  endfunction

  // Mostly unit-range headings, with the odd zero, axis or raw 16-bit value
  function automatic int pick_heading();
    case ($urandom_range(0, 9))
      0:       return int'($urandom);
      1:       return 0;
      2:       return 16384;
      3:       return -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // Hold the command until it transfers, then maybe idle for a burst
  task automatic send(lws_item_t it);
    item_i = it;
    start  = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (it.command != CMD_NONE) sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic push_pt(int x, int y);
    send(pack_cmd(CMD_PUSH, x, y, int'($urandom), int'($urandom)));
  endtask

  task automatic end_path();
    send(pack_cmd(CMD_END, int'($urandom), int'($urandom), int'($urandom), int'($urandom)));
  endtask

  task automatic set_pose(int x, int y, int c, int s);
    pose_x_now = x;
    pose_y_now = y;
    send(pack_cmd(CMD_POSE, x, y, c, s));
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Threshold writes happen only with the block drained; every phase ends on an end command
  task automatic set_reach(logic [THR_W-1:0] value);
    wait_idle();
    repeat (8) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    reach_now   = value;
    settings++;
  endtask

  // Usually a new pose, then a short path with random content, then the end command
  task automatic random_path();
    int len;
    int span;
    int k;
    int j;
    int x;
    int y;
    int seen_x [$];
    int seen_y [$];
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 4) == 0)
        set_pose(any_coord(), any_coord(), pick_heading(), pick_heading());
      else
        set_pose(int'($urandom_range(0, 2_000_000)) - 1_000_000,
                 int'($urandom_range(0, 2_000_000)) - 1_000_000,
                 pick_heading(), pick_heading());
    end
    case ($urandom_range(0, 3))
      0:       span = int'(reach_now) + int'(reach_now) / 2 + 16;
      1:       span = 64;
      2:       span = 1 << 20;
      default: span = 0;
    endcase
    case ($urandom_range(0, 19))
      0:       len = 0;
      1:       len = $urandom_range(11, 40);
      default: len = $urandom_range(1, 10);
    endcase
    for (k = 0; k < len; k++) begin
      if (seen_x.size() > 0 && $urandom_range(0, 7) == 0) begin
        // repeat an earlier point to force a distance tie
        j = $urandom_range(0, seen_x.size() - 1);
        x = seen_x[j];
        y = seen_y[j];
      end else if (span == 0) begin
        x = any_coord();
        y = any_coord();
      end else begin
        x = coord_near(pose_x_now, span);
        y = coord_near(pose_y_now, span);
      end
      seen_x = {seen_x, x};
      seen_y = {seen_y, y};
      push_pt(x, y);
      if ($urandom_range(0, 39) == 0)
        send(pack_cmd(CMD_NONE, any_coord(), any_coord(), int'($urandom), int'($urandom)));
      if ($urandom_range(0, 59) == 0) begin
        // pose mid-path restarts it
        set_pose(pose_x_now, pose_y_now, pick_heading(), pick_heading());
        seen_x.delete();
        seen_y.delete();
      end
    end
    end_path();
    if ($urandom_range(0, 19) == 0) end_path();
    if ($urandom_range(0, 9) == 0) wait_idle();
  endtask

  function automatic logic [THR_W-1:0] phase_reach(int p);
    case (p)
      0:       return THR_W'(8388607);
      1:       return THR_W'(1);
      2:       return THR_RESET;
      3:       return THR_W'($urandom_range(0, 4095));
      4:       return THR_W'($urandom_range(0, 8388607));
      5:       return THR_W'(0);
      6:       return THR_W'($urandom_range(0, 65535));
      default: return THR_W'($urandom_range(256, 20000));
    endcase
  endfunction

  initial begin
    int k;
    int p;
    int rand_base;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    gaps_on     = 1'b1;
    reach_now   = THR_RESET;
    sent        = 0;
    settings    = 1;
    pose_x_now  = 0;
    pose_y_now  = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty path straight out of reset, threshold at its reset value
    end_path();
    // tie on distance where only the earlier point qualifies, extremes, ignored code
    set_pose(0, 0, 16384, 0);
    push_pt(3000, 0);
    push_pt(-3000, 0);
    push_pt(COORD_MAX, COORD_MAX);
    push_pt(COORD_MIN, COORD_MIN);
    send(pack_cmd(CMD_NONE, -1, -1, -1, -1));
    end_path();
    // second end right away sees a cleared path with the pose kept
    end_path();
    // heading outside the unit range, corner pose, point on the pose itself
    set_pose(COORD_MAX, COORD_MIN, -32768, 32767);
    push_pt(COORD_MIN, COORD_MAX);
    push_pt(COORD_MAX, COORD_MIN);
    end_path();
    // exactly at the threshold does not count, one unit past it does
    set_pose(0, 0, 0, -16384);
    push_pt(0, -1280);
    push_pt(0, -1281);
    end_path();
    // nothing ahead: falls back to the nearest point
    set_pose(0, 0, 16384, 0);
    push_pt(-10, 0);
    end_path();
    // pose followed directly by end
    set_pose(0, 0, 16384, 0);
    end_path();

    // Fill the store past capacity; only the last stored point lies ahead
    set_reach(THR_W'(0));
    set_pose(0, 0, 16384, 0);
    for (k = 0; k < int'(MAX_POINTS) + 3; k++) begin
      if (k < int'(MAX_POINTS) - 1)
        push_pt(-int'($urandom_range(0, 4_000_000)), coord_near(0, 1 << 20));
      else if (k == int'(MAX_POINTS) - 1)
        push_pt(int'($urandom_range(1, COORD_MAX)), coord_near(0, 1 << 20));
      else
        push_pt(any_coord(), any_coord());
    end
    end_path();

    // Random paths over a sweep of thresholds, no idling near the end
    rand_base = sent;
    for (p = 0; p < 8; p++) begin
      set_reach(phase_reach(p));
      while (sent < rand_base + RAND_ITEMS * (p + 1) / 8) begin
        if (sent >= rand_base + RAND_ITEMS - QUIET_TAIL)
          gaps_on = 1'b0;
        else
          gaps_on = ($urandom_range(0, 3) != 0);
        random_path();
      end
    end

    wait_idle();
    repeat (64) @(negedge clk_i);
    $display("%0d commands transferred, %0d selections checked, %0d with a point ahead",
             sent, checked, ahead_hits);
    $display("%0d threshold settings used, store filled past capacity once", settings);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
